/* rtl/core/irdla_pkg.sv */
package irdla_pkg;

  localparam int MEAS_W      = 12;
  localparam int DIST_W      = 15;
  localparam int IN_TDATA_W  = 16;
  localparam int OUT_TDATA_W = 32;
  localparam int OUT_PAD_W   = OUT_TDATA_W - 2 * DIST_W;

  // Breakpoint table: ADC counts and Q1.14 distances
  localparam int POINT_COUNT = 6;
  localparam int SEG_COUNT   = POINT_COUNT - 1;
  localparam int SEG_W       = $clog2(SEG_COUNT);

  localparam logic [MEAS_W-1:0] BP_ADC [POINT_COUNT] = '{
    12'd800, 12'd830, 12'd900, 12'd1150, 12'd1650, 12'd2700
  };
  localparam logic [DIST_W-1:0] BP_DIST [POINT_COUNT] = '{
    15'd21299, 15'd16384, 15'd13107, 15'd9830, 15'd6554, 15'd3277
  };

  // Fall per ADC count in unsigned Q.16, rounded to nearest
  localparam int SLOPE_SHIFT = 16;
  localparam int SLOPE_W     = 24;
  localparam logic [SLOPE_W-1:0] SEG_SLOPE [SEG_COUNT] = '{
    SLOPE_W'(((21299 - 16384) * 65536 + 30 / 2) / 30),
    SLOPE_W'(((16384 - 13107) * 65536 + 70 / 2) / 70),
    SLOPE_W'(((13107 - 9830) * 65536 + 250 / 2) / 250),
    SLOPE_W'(((9830 - 6554) * 65536 + 500 / 2) / 500),
    SLOPE_W'(((6554 - 3277) * 65536 + 1050 / 2) / 1050)
  };
  localparam int PROD_W = MEAS_W + SLOPE_W;
  localparam int FALL_W = PROD_W - SLOPE_SHIFT;

  // Moving average
  localparam int WINDOW      = 3;
  localparam int POS_W       = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int TOTAL_W     = 19;
  localparam int NUM_W       = TOTAL_W + 1;
  localparam int DIV_SHIFT   = NUM_W + 4;
  localparam int RECIP_W     = DIV_SHIFT + 1;
  localparam logic [RECIP_W-1:0] RECIP =
    RECIP_W'(((64'd1 << DIV_SHIFT) + 64'(WINDOW) - 64'd1) / 64'(WINDOW));
  localparam int AVG_PROD_W  = NUM_W + RECIP_W;

endpackage

/* rtl/core/irdla_linearize.sv */
module irdla_linearize
  import irdla_pkg::*;
(
  input  logic [MEAS_W-1:0] measurement_i,
  output logic [DIST_W-1:0] distance_o
);

  logic [SEG_W-1:0]  seg;
  logic [MEAS_W-1:0] offset;
  logic [PROD_W-1:0] prod;
  logic [PROD_W-1:0] rounded;
  logic [FALL_W-1:0] fall;
  logic [DIST_W-1:0] upper;

  always_comb begin
    // breakpoints are ascending, so the last hit is the segment
    seg = '0;
    for (int k = 1; k < SEG_COUNT; k++) begin
      if (measurement_i > BP_ADC[k]) seg = SEG_W'(k);
    end
    offset  = measurement_i - BP_ADC[seg];
    prod    = PROD_W'(offset) * PROD_W'(SEG_SLOPE[seg]);
    rounded = prod + (PROD_W'(1) << (SLOPE_SHIFT - 1));
    fall    = rounded[PROD_W-1:SLOPE_SHIFT];
    upper   = BP_DIST[seg];

    if (measurement_i <= BP_ADC[0]) begin
      distance_o = BP_DIST[0];
    end else if (measurement_i >= BP_ADC[POINT_COUNT-1]) begin
      distance_o = BP_DIST[POINT_COUNT-1];
    end else if (fall > FALL_W'(upper)) begin
      distance_o = '0;
    end else begin
      distance_o = upper - fall[DIST_W-1:0];
    end
  end

endmodule

/* rtl/core/irdla_average.sv */
module irdla_average
  import irdla_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              write_en_i,
  input  logic [DIST_W-1:0] distance_i,
  output logic [DIST_W-1:0] average_o
);

  logic [DIST_W-1:0]     store_q [WINDOW];
  logic [POS_W-1:0]      pos_q, pos_d;
  logic [TOTAL_W-1:0]    total_q, total_d;
  logic [NUM_W-1:0]      num;
  logic [AVG_PROD_W-1:0] prod;

  always_comb begin
    total_d = total_q - TOTAL_W'(store_q[pos_q]) + TOTAL_W'(distance_i);
    pos_d   = (pos_q == POS_W'(WINDOW - 1)) ? '0 : pos_q + POS_W'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < WINDOW; k++) store_q[k] <= '0;
      pos_q   <= '0;
      total_q <= '0;
    end else if (write_en_i) begin
      store_q[pos_q] <= distance_i;
      pos_q          <= pos_d;
      total_q        <= total_d;
    end
  end

  // divide by the window length through a reciprocal multiply
  always_comb begin
    num       = NUM_W'(total_q) + NUM_W'(WINDOW / 2);
    prod      = AVG_PROD_W'(num) * AVG_PROD_W'(RECIP);
    average_o = prod[DIV_SHIFT +: DIST_W];
  end

endmodule

/* rtl/core/ir_distance_linearize_average.sv */
// Infrared distance linearizer with moving average. Each input item carries a
// 12-bit ADC reading; the block maps it to a distance in unsigned Q1.14 metres
// by piecewise-linear interpolation over six fixed breakpoints (clamped to
// 1.30 m and 0.20 m outside the table) and returns it together with the
// rounded mean of the last three distances. The window starts out as zeros,
// so the first averages are low. One item is taken every clock cycle while the
// output is not stalled; a result is registered in turn in an input register,
// a stage that holds the interpolated distance and the running sum, and the
// output register that follows the divide-by-window multiply.
module ir_distance_linearize_average
  import irdla_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,   // [11:0] measurement
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata    // [14:0] distance, [29:15] distance_averaged
);

  logic              v0_q, v1_q, v2_q;
  logic              adv0, adv1, adv2;
  logic [MEAS_W-1:0] meas_q;
  logic [DIST_W-1:0] lin_dist;
  logic [DIST_W-1:0] dist1_q;
  logic [DIST_W-1:0] avg;
  logic [DIST_W-1:0] dist_q;
  logic [DIST_W-1:0] avg_q;

  // a stage advances when it is empty or the next one advances
  assign adv2 = !v2_q || m_axis_tready;
  assign adv1 = !v1_q || adv2;
  assign adv0 = !v0_q || adv1;

  assign s_axis_tready = adv0;
  assign m_axis_tvalid = v2_q;
  assign m_axis_tdata  = {OUT_PAD_W'(0), avg_q, dist_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      if (adv0) v0_q <= s_axis_tvalid;
      if (adv1) v1_q <= v0_q;
      if (adv2) v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv0 && s_axis_tvalid) meas_q <= s_axis_tdata[MEAS_W-1:0];
    if (adv1 && v0_q) dist1_q <= lin_dist;
    if (adv2 && v1_q) begin
      dist_q <= dist1_q;
      avg_q  <= avg;
    end
  end

  irdla_linearize u_linearize (
    .measurement_i (meas_q),
    .distance_o    (lin_dist)
  );

  // the running sum moves together with the distance stage
  irdla_average u_average (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .write_en_i (adv1 && v0_q),
    .distance_i (lin_dist),
    .average_o  (avg)
  );

endmodule

/* tb/irdla_distance_checker.sv */
`timescale 1ns / 100ps

module irdla_distance_checker
  import irdla_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_tvalid_i,
  input  logic                   s_tready_i,
  input  logic [IN_TDATA_W-1:0]  s_tdata_i,   // [11:0] measurement
  input  logic                   m_tvalid_i,
  input  logic                   m_tready_i,
  input  logic [OUT_TDATA_W-1:0] m_tdata_i,   // [14:0] distance, [29:15] distance_averaged
  output int                     mismatch_count_o,
  output int                     pending_count_o,
  output int                     checked_count_o
);

  localparam int KNEES    = 6;
  localparam int AVG_SPAN = 3;
  localparam int SUM_W    = 19;

  // ADC counts and Q1.14 distances of the sensor curve
  localparam longint KNEE_ADC  [KNEES] = '{800, 830, 900, 1150, 1650, 2700};
  localparam longint KNEE_DIST [KNEES] = '{21299, 16384, 13107, 9830, 6554, 3277};

  typedef struct packed {
    logic [DIST_W-1:0] distance;
    logic [DIST_W-1:0] average;
  } dist_pair_t;

  dist_pair_t        expected_dist_q [$];
  dist_pair_t        want;
  dist_pair_t        got;
  logic [DIST_W-1:0] recent_dist [AVG_SPAN];
  logic [SUM_W-1:0]  recent_sum;
  int                recent_slot;
  int                mismatch_n;
  int                checked_n;

  assign mismatch_count_o = mismatch_n;
  assign pending_count_o  = expected_dist_q.size();
  assign checked_count_o  = checked_n;

  function automatic logic [DIST_W-1:0] reading_to_distance(input logic [MEAS_W-1:0] reading);
    longint r;
    longint span;
    longint slope;
    longint fall;
    int     seg;
    r = reading;
    if (r <= KNEE_ADC[0]) return DIST_W'(KNEE_DIST[0]);
    if (r >= KNEE_ADC[KNEES-1]) return DIST_W'(KNEE_DIST[KNEES-1]);
    seg = 0;
    while (seg < KNEES - 2 && r > KNEE_ADC[seg+1]) seg++;
    span  = KNEE_ADC[seg+1] - KNEE_ADC[seg];
    // fall per count in Q.16, then the fall itself, both rounded to nearest
    slope = ((KNEE_DIST[seg] - KNEE_DIST[seg+1]) * 65536 + span / 2) / span;
    fall  = ((r - KNEE_ADC[seg]) * slope + 32768) >>> 16;
    if (fall > KNEE_DIST[seg]) return '0;
    return DIST_W'(KNEE_DIST[seg] - fall);
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      expected_dist_q.delete();
      for (int k = 0; k < AVG_SPAN; k++) recent_dist[k] = '0;
      recent_sum  = '0;
      recent_slot = 0;
      mismatch_n  = 0;
      checked_n   = 0;
    end else begin
      if (s_tvalid_i && s_tready_i) begin
        want.distance = reading_to_distance(s_tdata_i[MEAS_W-1:0]);
        recent_sum = recent_sum - recent_dist[recent_slot] + want.distance;
        recent_dist[recent_slot] = want.distance;
        recent_slot = (recent_slot == AVG_SPAN - 1) ? 0 : recent_slot + 1;
        want.average = DIST_W'(((SUM_W+1)'(recent_sum) + (SUM_W+1)'(AVG_SPAN / 2)) / AVG_SPAN);
        expected_dist_q.push_back(want);
      end
      if (m_tvalid_i && m_tready_i) begin
        got.distance = m_tdata_i[DIST_W-1:0];
        got.average  = m_tdata_i[2*DIST_W-1:DIST_W];
        checked_n++;
        if (expected_dist_q.size() == 0) begin
          mismatch_n++;
          if (mismatch_n <= 10)
            $display("%0t: unexpected result distance=%0d average=%0d",
                     $realtime, got.distance, got.average);
        end else begin
          want = expected_dist_q.pop_front();
          if (got != want) begin
            mismatch_n++;
            if (mismatch_n <= 10)
              $display("%0t: distance exp %0d got %0d, average exp %0d got %0d",
                       $realtime, want.distance, got.distance, want.average, got.average);
          end
        end
      end
    end
  end

endmodule

/* tb/ir_distance_linearize_average_tb.sv */
`timescale 1ns / 100ps

module ir_distance_linearize_average_tb;
  import irdla_pkg::*;

  localparam int RANDOM_ITEMS = 550;
  localparam int CYCLE_LIMIT  = 200000;

  logic                   clk_i;
  logic                   rst_ni;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [IN_TDATA_W-1:0]  s_tdata  = '0;
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_tdata;

  int mismatch_count;
  int pending_count;
  int checked_count;
  int cycle_count = 0;
  int burst_left  = 0;
  int sent_count  = 0;
  int stall_mode  = 0;

  ir_distance_linearize_average DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_tvalid),
    .s_axis_tready (s_tready),
    .s_axis_tdata  (s_tdata),
    .m_axis_tvalid (m_tvalid),
    .m_axis_tready (m_tready),
    .m_axis_tdata  (m_tdata)
  );

  irdla_distance_checker u_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .s_tvalid_i       (s_tvalid),
    .s_tready_i       (s_tready),
    .s_tdata_i        (s_tdata),
    .m_tvalid_i       (m_tvalid),
    .m_tready_i       (m_tready),
    .m_tdata_i        (m_tdata),
    .mismatch_count_o (mismatch_count),
    .pending_count_o  (pending_count),
    .checked_count_o  (checked_count)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Receiver: switch periodically between four randomly chosen stall behaviors
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      m_tready <= 1'b0;
    end else begin
      if (cycle_count % 64 == 0) stall_mode <= $urandom_range(0, 3);
      case (stall_mode)
        0: m_tready <= 1'b1;
        1: m_tready <= ($urandom_range(0, 1) == 1);
        2: m_tready <= ($urandom_range(0, 3) == 0);
        default: m_tready <= ((cycle_count % 5) != 0);
      endcase
    end
  end

  // Send one item; work in bursts with random gaps in between
  task automatic send_reading(input logic [IN_TDATA_W-1:0] word);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = $urandom_range(0, 6);
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    s_tvalid <= 1'b1;
    s_tdata  <= word;
    @(posedge clk_i);
    while (!s_tready) @(posedge clk_i);
    burst_left--;
    sent_count++;
  endtask

  initial begin
    automatic logic [MEAS_W-1:0] knees [6] = '{800, 830, 900, 1150, 1650, 2700};
    automatic logic [MEAS_W-1:0] directed [] = '{
      0, 4095, 799, 800, 801, 815, 829, 830, 831, 865, 900, 1000,
      1149, 1150, 1151, 1400, 1650, 2200, 2699, 2700, 2701
    };
    int kind;
    logic [MEAS_W-1:0] reading;

    rst_ni = 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // clamps, breakpoints, the neighbors of four of them, one point inside each segment
    foreach (directed[i]) send_reading(IN_TDATA_W'(directed[i]));
    // bits above the reading must be ignored
    send_reading({4'hF, 12'd1000});
    send_reading({4'hA, 12'd2699});

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      kind = $urandom_range(0, 9);
      if (kind < 2)
        reading = MEAS_W'($urandom_range(0, 4095));
      else if (kind < 4)
        reading = MEAS_W'(knees[$urandom_range(0, 5)] + $urandom_range(0, 6) - 3);
      else
        reading = MEAS_W'($urandom_range(800, 2700));
      send_reading(IN_TDATA_W'(reading));
    end
    s_tvalid <= 1'b0;

    @(posedge clk_i);
    while (pending_count != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);

    $display("%0d readings sent over clamps, breakpoints and segments; %0d results checked",
             sent_count, checked_count);
    $display("%0d mismatches, %0d results still outstanding", mismatch_count, pending_count);
    if (mismatch_count == 0 && pending_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
